[design/scmp_pkg.sv]
// Shared types, constants and elaboration-time tables for the stereo compressor.
// No dependencies; imported by every other file of the block.
package scmp_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LOG_DEPTH_DEF   = 256;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  localparam logic [14:0] DB_FLOOR_MAG = 15'd24576;   // 96 dB in Q8.8
  localparam logic [18:0] DB_PER_LOG2  = 19'd394566;  // 20*log10(2), Q16
  localparam logic [13:0] LOG2_PER_DB  = 14'd10885;   // 1/(20*log10(2)), Q16

  typedef enum logic [2:0] {
    REG_ENABLE, REG_THRESH, REG_IRATIO, REG_KNEE, REG_ATTACK, REG_RELEASE, REG_MAKEUP
  } reg_idx_t;

  typedef struct packed {
    logic        enable;
    logic [14:0] threshold_db;
    logic [15:0] inverse_ratio;
    logic [12:0] knee_db;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [14:0] makeup_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_NORM, CMD_LOGI, CMD_LOGSQ, CMD_LVL, CMD_ENV1, CMD_ENV2,
    CMD_REGION, CMD_HARD, CMD_KNEE1, CMD_KNEE2, CMD_DIV, CMD_NLOG, CMD_EXP,
    CMD_SHIFT, CMD_MKUP, CMD_SCL, CMD_SCR, CMD_PUSH
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] step;
  } dp_cmd_t;

  typedef enum logic [1:0] {RG_BELOW, RG_KNEE, RG_ABOVE} region_t;

  typedef struct packed {
    region_t region;
    logic    out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_LOGI, S_LOGSQ, S_LVL, S_ENV1, S_ENV2, S_REGION, S_HARD,
    S_KNEE1, S_KNEE2, S_DIV, S_NLOG, S_EXP, S_SHIFT, S_MKUP, S_SCL, S_SCR, S_DONE
  } state_t;

  typedef logic [15:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // entry k: 2^-(2^(k-16)) in Q1.30, each the floor sqrt of the one above it
  function automatic root_tab_t exp_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int k = 15; k >= 0; k--) begin
      t[k] = r[30:0];
      r    = isqrt64(r << 30);
    end
    return t;
  endfunction

  localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

[design/scmp_regs.sv]
// APB-style configuration register file of the compressor.
// Depends on scmp_pkg (cfg_t, register indexes).
module scmp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scmp_pkg::ADDR_W-1:0] paddr,
  input  logic [scmp_pkg::DATA_W-1:0] pwdata,
  output logic [scmp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output scmp_pkg::cfg_t              cfg
);
  import scmp_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.threshold_db  <= '0;
      cfg.inverse_ratio <= 16'd32768;
      cfg.knee_db       <= '0;
      cfg.attack_coeff  <= 16'd64000;
      cfg.release_coeff <= 16'd65400;
      cfg.makeup_gain   <= 15'd1024;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE:  cfg.enable        <= pwdata[0];
        REG_THRESH:  cfg.threshold_db  <= pwdata[14:0];
        REG_IRATIO:  cfg.inverse_ratio <= pwdata[15:0];
        REG_KNEE:    cfg.knee_db       <= pwdata[12:0];
        REG_ATTACK:  cfg.attack_coeff  <= pwdata[15:0];
        REG_RELEASE: cfg.release_coeff <= pwdata[15:0];
        REG_MAKEUP:  cfg.makeup_gain   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:  prdata = {31'd0, cfg.enable};
      REG_THRESH:  prdata = {17'd0, cfg.threshold_db};
      REG_IRATIO:  prdata = {16'd0, cfg.inverse_ratio};
      REG_KNEE:    prdata = {19'd0, cfg.knee_db};
      REG_ATTACK:  prdata = {16'd0, cfg.attack_coeff};
      REG_RELEASE: prdata = {16'd0, cfg.release_coeff};
      REG_MAKEUP:  prdata = {17'd0, cfg.makeup_gain};
      default:     prdata = '0;
    endcase
  end

endmodule

[design/scmp_ctrl.sv]
// Sequencer of the compressor: walks the datapath through one frame.
// Depends on scmp_pkg (state, command and status types).
module scmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  scmp_pkg::dp_stat_t stat,
  output scmp_pkg::dp_cmd_t  cmd
);
  import scmp_pkg::*;

  state_t     state, state_next;
  logic [3:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and step count
  always_comb begin
    state_next = state;
    step_next  = '0;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = enable ? S_NORM : S_DONE;
      S_NORM: begin
        if (step == 4'd4) state_next = S_LOGI;
        else step_next = step + 4'd1;
      end
      S_LOGI:   state_next = S_LOGSQ;
      S_LOGSQ: begin
        if (step == 4'd15) state_next = S_LVL;
        else step_next = step + 4'd1;
      end
      S_LVL:    state_next = S_ENV1;
      S_ENV1:   state_next = S_ENV2;
      S_ENV2:   state_next = S_REGION;
      S_REGION: begin
        case (stat.region)
          RG_ABOVE: state_next = S_HARD;
          RG_KNEE:  state_next = S_KNEE1;
          default:  state_next = S_NLOG;
        endcase
      end
      S_HARD:   state_next = S_NLOG;
      S_KNEE1:  state_next = S_KNEE2;
      S_KNEE2:  state_next = S_DIV;
      S_DIV: begin
        if (step == 4'd13) state_next = S_NLOG;
        else step_next = step + 4'd1;
      end
      S_NLOG:   state_next = S_EXP;
      S_EXP: begin
        if (step == 4'd15) state_next = S_SHIFT;
        else step_next = step + 4'd1;
      end
      S_SHIFT:  state_next = S_MKUP;
      S_MKUP:   state_next = S_SCL;
      S_SCL:    state_next = S_SCR;
      S_SCR:    state_next = S_DONE;
      S_DONE:   if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.step = step;
    unique case (state)
      S_IDLE:   cmd.cmd = in_valid ? CMD_LOAD : CMD_NOP;
      S_NORM:   cmd.cmd = CMD_NORM;
      S_LOGI:   cmd.cmd = CMD_LOGI;
      S_LOGSQ:  cmd.cmd = CMD_LOGSQ;
      S_LVL:    cmd.cmd = CMD_LVL;
      S_ENV1:   cmd.cmd = CMD_ENV1;
      S_ENV2:   cmd.cmd = CMD_ENV2;
      S_REGION: cmd.cmd = CMD_REGION;
      S_HARD:   cmd.cmd = CMD_HARD;
      S_KNEE1:  cmd.cmd = CMD_KNEE1;
      S_KNEE2:  cmd.cmd = CMD_KNEE2;
      S_DIV:    cmd.cmd = CMD_DIV;
      S_NLOG:   cmd.cmd = CMD_NLOG;
      S_EXP:    cmd.cmd = CMD_EXP;
      S_SHIFT:  cmd.cmd = CMD_SHIFT;
      S_MKUP:   cmd.cmd = CMD_MKUP;
      S_SCL:    cmd.cmd = CMD_SCL;
      S_SCR:    cmd.cmd = CMD_SCR;
      S_DONE:   cmd.cmd = stat.out_free ? CMD_PUSH : CMD_NOP;
      default:  cmd.cmd = CMD_NOP;
    endcase
  end

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> step <= 4'd13)
    else $error("divider ran past its last quotient bit");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !enable |=> state == S_DONE)
    else $error("bypass word did not go straight to output");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !stat.out_free |=> state == S_DONE)
    else $error("result dropped while output stage full");

endmodule

[design/scmp_dp.sv]
// Datapath of the compressor: one shared multiplier, step registers,
// divider and output register. Depends on scmp_pkg (cmd/status, roots).
module scmp_dp #(
  parameter int SAMPLE_BITS     = scmp_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = scmp_pkg::LOG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scmp_pkg::cfg_t                cfg,
  input  scmp_pkg::dp_cmd_t             cmd,
  output scmp_pkg::dp_stat_t            stat,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic                          block_end,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          block_end_out,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import scmp_pkg::*;

  localparam int W    = SAMPLE_BITS;
  localparam int LD   = $clog2(LOG_TABLE_DEPTH);
  localparam int PADW = 32 - W;
  localparam logic [37:0] LIM = 38'd1 << (W - 1);

  logic [W-1:0]  mag_l, mag_r, nv, res_l, res_r;
  logic          neg_l, neg_r, pz, res_be;
  logic [4:0]    cnt;
  logic [31:0]   y;
  logic [15:0]   lr;
  logic [14:0]   lvl_mag, env_mag, dpos, gmag;
  logic [16:0]   cinv;
  logic [31:0]   acc;
  logic [13:0]   xk;
  logic [29:0]   tq;
  logic [26:0]   nrem;
  logic [4:0]    nint;
  logic [15:0]   nfrac;
  logic [30:0]   v;
  logic [25:0]   g;

  logic [W-1:0]  lu, ru, in_mag_l, in_mag_r, peak;
  logic [31:0]   ma, mb;
  logic [63:0]   prod;
  logic [15:0]   ir_c, q, c_sel;
  logic [20:0]   m_val;
  logic [30:0]   mfrac;
  logic [LD-1:0] idx;
  logic [31:0]   sq;
  logic [40:0]   lsum;
  logic [16:0]   lvl_raw;
  logic [32:0]   esum;
  logic signed [17:0] dval;
  logic signed [18:0] d2, kn_s, xsum;
  region_t       region;
  logic [3:0]    ebit, dbit;
  logic [26:0]   dsh;
  logic [30:0]   ns;
  logic [45:0]   gs;
  logic [57:0]   ps;

  function automatic logic [W-1:0] sat_scale(input logic neg, input logic [37:0] p);
    logic [W-1:0] r;
    if (p >= LIM) r = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else          r = neg ? (~p[W-1:0] + W'(1)) : p[W-1:0];
    return r;
  endfunction

  assign lu       = left_in;
  assign ru       = right_in;
  assign in_mag_l = lu[W-1] ? (~lu + W'(1)) : lu;
  assign in_mag_r = ru[W-1] ? (~ru + W'(1)) : ru;
  assign peak     = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;

  assign ir_c  = (cfg.inverse_ratio > 16'd32768) ? 16'd32768 : cfg.inverse_ratio;
  assign q     = 16'd32768 - ir_c;
  assign c_sel = (lvl_mag < env_mag) ? cfg.attack_coeff : cfg.release_coeff;
  assign m_val = {cnt, 16'h0000} - 21'(lr);
  assign mfrac = 31'(nv[W-2:0]) << PADW;
  assign idx   = mfrac[30 -: LD];
  assign ebit  = 4'd15 - cmd.step;
  assign dbit  = 4'd13 - cmd.step;

  // gain-computer region from the freshly updated envelope
  assign dval = $signed(18'd0 - {3'b000, env_mag}
                - {{3{cfg.threshold_db[14]}}, cfg.threshold_db});
  assign d2   = $signed({dval, 1'b0});
  assign kn_s = $signed({6'd0, cfg.knee_db});
  assign xsum = d2 + kn_s;
  always_comb begin
    if (d2 <= -kn_s)     region = RG_BELOW;
    else if (d2 >= kn_s) region = RG_ABOVE;
    else                 region = RG_KNEE;
  end

  assign stat.region   = region;
  assign stat.out_free = !out_valid || out_ready;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.cmd)
      CMD_LOGSQ: begin ma = y;             mb = y;                    end
      CMD_LVL:   begin ma = 32'(m_val);    mb = 32'(DB_PER_LOG2);     end
      CMD_ENV1:  begin ma = 32'(c_sel);    mb = 32'(env_mag);         end
      CMD_ENV2:  begin ma = 32'(cinv);     mb = 32'(lvl_mag);         end
      CMD_HARD:  begin ma = 32'(dpos);     mb = 32'(q);               end
      CMD_KNEE1: begin ma = 32'(q);        mb = 32'(xk);              end
      CMD_KNEE2: begin ma = 32'(tq);       mb = 32'(xk);              end
      CMD_NLOG:  begin ma = 32'(gmag);     mb = 32'(LOG2_PER_DB);     end
      CMD_EXP:   begin ma = 32'(v);        mb = 32'(EXP_ROOT[ebit]);  end
      CMD_MKUP:  begin ma = 32'(v);        mb = 32'(cfg.makeup_gain); end
      CMD_SCL:   begin ma = 32'(mag_l);    mb = 32'(g);               end
      CMD_SCR:   begin ma = 32'(mag_r);    mb = 32'(g);               end
      default: ;
    endcase
  end
  assign prod = 64'(ma) * 64'(mb);

  assign sq      = prod[61:30];
  assign lsum    = prod[40:0] + (41'd1 << 23);
  assign lvl_raw = lsum[40:24];
  assign esum    = 33'(acc) + 33'(prod[31:0]) + 33'd32768;
  assign dsh     = 27'(cfg.knee_db) << dbit;
  assign ns      = prod[30:0] + 31'd128;
  assign gs      = prod[45:0] + (46'd1 << 19);
  assign ps      = prod[57:0] + (58'd1 << 19);

  always_ff @(posedge clk) begin
    case (cmd.cmd)
      CMD_LOAD: begin
        mag_l  <= in_mag_l;
        mag_r  <= in_mag_r;
        neg_l  <= lu[W-1];
        neg_r  <= ru[W-1];
        nv     <= peak;
        pz     <= (peak == '0);
        cnt    <= '0;
        res_l  <= lu;
        res_r  <= ru;
        res_be <= block_end;
      end
      CMD_NORM: begin
        case (cmd.step[2:0])
          3'd0: if (nv[W-1 -: 16] == '0) begin nv <= nv << 16; cnt <= cnt + 5'd16; end
          3'd1: if (nv[W-1 -: 8] == '0)  begin nv <= nv << 8;  cnt <= cnt + 5'd8;  end
          3'd2: if (nv[W-1 -: 4] == '0)  begin nv <= nv << 4;  cnt <= cnt + 5'd4;  end
          3'd3: if (nv[W-1 -: 2] == '0)  begin nv <= nv << 2;  cnt <= cnt + 5'd2;  end
          default: if (!nv[W-1])         begin nv <= nv << 1;  cnt <= cnt + 5'd1;  end
        endcase
      end
      CMD_LOGI: begin
        y  <= 32'({1'b1, idx}) << (30 - LD);
        lr <= '0;
      end
      CMD_LOGSQ: begin
        if (sq[31]) begin
          y  <= {1'b0, sq[31:1]};
          lr <= {lr[14:0], 1'b1};
        end else begin
          y  <= sq;
          lr <= {lr[14:0], 1'b0};
        end
      end
      CMD_LVL: begin
        if (pz || lvl_raw > 17'(DB_FLOOR_MAG)) lvl_mag <= DB_FLOOR_MAG;
        else                                   lvl_mag <= lvl_raw[14:0];
      end
      CMD_ENV1: begin
        acc  <= prod[31:0];
        cinv <= 17'h10000 - 17'(c_sel);
      end
      CMD_REGION: begin
        dpos <= dval[14:0];
        xk   <= xsum[13:0];
        gmag <= '0;
      end
      CMD_HARD:  gmag <= 15'((prod[29:0] + 30'd16384) >> 15);
      CMD_KNEE1: tq   <= prod[29:0];
      CMD_KNEE2: nrem <= 27'((prod[43:0] + (44'(cfg.knee_db) << 17)) >> 18);
      CMD_DIV: begin
        if (nrem >= dsh) begin
          nrem       <= nrem - dsh;
          gmag[dbit] <= 1'b1;
        end
      end
      CMD_NLOG: begin
        nint  <= ns[28:24];
        nfrac <= ns[23:8];
        v     <= 31'h4000_0000;
      end
      CMD_EXP:   if (nfrac[ebit]) v <= prod[60:30];
      CMD_SHIFT: v <= (nint == 5'd31) ? '0 : (v >> nint);
      CMD_MKUP:  g <= gs[45:20];
      CMD_SCL:   res_l <= sat_scale(neg_l, ps[57:20]);
      CMD_SCR:   res_r <= sat_scale(neg_r, ps[57:20]);
      CMD_PUSH: begin
        left_out      <= $signed(res_l);
        right_out     <= $signed(res_r);
        block_end_out <= res_be;
      end
      default: ;
    endcase
  end

  // envelope is state: reset to the floor
  always_ff @(posedge clk) begin
    if (rst)                      env_mag <= DB_FLOOR_MAG;
    else if (cmd.cmd == CMD_ENV2) env_mag <= esum[30:16];
  end

  always_ff @(posedge clk) begin
    if (rst)                      out_valid <= 1'b0;
    else if (cmd.cmd == CMD_PUSH) out_valid <= 1'b1;
    else if (out_ready)           out_valid <= 1'b0;
  end

  a_env_floor: assert property (@(posedge clk) disable iff (rst)
    env_mag <= DB_FLOOR_MAG)
    else $error("envelope below the -96 dB floor");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.cmd == CMD_PUSH |-> (!out_valid || out_ready))
    else $error("push into an occupied output stage");

endmodule

[design/stereo_soft_knee_compressor_core.sv]
// Top level of the stereo soft-knee compressor: registers, sequencer, datapath.
// Depends on scmp_pkg, scmp_regs, scmp_ctrl and scmp_dp.
//
// Usage:
//  - Input channel in_valid/in_ready carries one stereo word (left_in,
//    right_in, block_end). Output channel out_valid/out_ready returns one
//    word per input word, in order, with block_end copied through.
//  - APB-style port holds the seven settings at byte addresses 0,4,...,24.
//    Change them only while the block is idle.
//  - With compression on, a word runs through normalise, log2, level,
//    envelope and region steps, plus one product step above the knee or
//    two product steps and 14 divider steps inside it, then exp2, shift,
//    makeup, both scalings and the push. One word is in flight at a time;
//    the next accept can come in the cycle after the push. All arithmetic
//    shares one 32x32 multiplier; the 16-step log2 and exp2 loops dominate.
//  - Disabled: the word passes unchanged, going from accept straight to the
//    push into the output register; the envelope holds.
//  - Output register decouples the sides: while a finished word waits for
//    out_ready the next word can be accepted and processed; the sequencer
//    then holds its result until the output register frees up.
//  - Reset (rst, synchronous) restores the register defaults, sets the
//    envelope to -96 dB and empties the output stage.
module stereo_soft_knee_compressor_core #(
  parameter int SAMPLE_BITS     = scmp_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = scmp_pkg::LOG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scmp_pkg::ADDR_W-1:0]   paddr,
  input  logic [scmp_pkg::DATA_W-1:0]   pwdata,
  output logic [scmp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          block_end_out
);
  import scmp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // settings
  scmp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // sequencer: one state per datapath command; the looped ones count their steps
  scmp_ctrl u_ctrl (
    .clk, .rst,
    .enable   (cfg.enable),
    .in_valid,
    .in_ready,
    .stat,
    .cmd
  );

  // arithmetic, envelope state and output register
  scmp_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .stat,
    .left_in, .right_in, .block_end,
    .left_out, .right_out, .block_end_out,
    .out_valid, .out_ready
  );

endmodule

[sim/stereo_soft_knee_compressor_core_test.sv]
// Self-checking testbench for stereo_soft_knee_compressor_core: APB setup, stereo words
// in, a bit-exact compressor predictor and an in-order scoreboard out. Depends on scmp_pkg.
module stereo_soft_knee_compressor_core_test;
  import scmp_pkg::*;

  localparam int SB        = 24;
  localparam int CYC_LIMIT = 2000000;
  localparam int SETTLE    = 80;

  typedef struct packed {
    logic signed [SB-1:0] l;
    logic signed [SB-1:0] r;
    logic                 be;
  } frame_t;

  // directed row: seg picks the register setting, known marks a typed-in result
  typedef struct {
    int                   seg;
    logic signed [SB-1:0] l;
    logic signed [SB-1:0] r;
    logic                 be;
    logic                 known;
    logic signed [SB-1:0] el;
    logic signed [SB-1:0] er;
  } dir_row_t;

  localparam logic signed [SB-1:0] FS_POS = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] FS_NEG = 24'sh800000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, block_end, out_valid, out_ready, block_end_out;
  logic signed [SB-1:0] left_in, right_in, left_out, right_out;

  // typed-in result travels with the word it belongs to
  logic                 known_q;
  logic signed [SB-1:0] known_l, known_r;

  cfg_t              shadow_cfg;
  int                env_db;            // envelope, Q8.8
  logic [31:0]       log_tab [256];
  longint unsigned   root_tab [16];
  frame_t            expected_frames [$];
  int                errors;
  int                cycles;
  int                send_idle_pct, recv_stall_pct;

  stereo_soft_knee_compressor_core u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .left_in, .right_in, .block_end,
    .out_valid, .out_ready, .left_out, .right_out, .block_end_out
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem, root, probe;
    rem  = v;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      probe = (root << (b + 1)) + (64'd1 << (2 * b));
      if (probe <= rem) begin
        rem  = rem - probe;
        root = root | (64'd1 << b);
      end
    end
    return root;
  endfunction

  // log2(1 + i/256) in Q16 by repeated squaring; 2^-(2^(k-16)) roots in Q1.30
  task automatic build_tables();
    longint unsigned y, rt;
    logic [31:0] acc;
    for (int i = 0; i < 256; i++) begin
      y   = ((64'd256 + i) << 30) / 256;
      acc = 0;
      for (int k = 0; k < 16; k++) begin
        y   = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'd1 << 31)) begin
          y      = y >> 1;
          acc[0] = 1'b1;
        end
      end
      log_tab[i] = acc;
    end
    rt = int_sqrt(64'd1 << 59);
    for (int k = 15; k >= 0; k--) begin
      root_tab[k] = rt;
      rt = int_sqrt(rt << 30);
    end
  endtask

  function automatic logic signed [SB-1:0] apply_gain(input logic signed [SB-1:0] s,
                                                       input longint unsigned g);
    longint unsigned mag, p;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    p   = (mag * g + (64'd1 << 19)) >> 20;
    if (s < 0) return (p >= (64'd1 << 23)) ? FS_NEG : SB'(-longint'(p));
    return (p >= (64'd1 << 23)) ? FS_POS : SB'(p);
  endfunction

  // one frame through the compressor; updates env_db when enabled
  function automatic frame_t compress_frame(input frame_t f);
    frame_t          o;
    longint unsigned lm, rm, peak, frac, idx, m, lvl_mag, c, env_mag, q, gmag, n, lin, g;
    longint unsigned x, den;
    longint          d, d2, kn, thr;
    int              p;
    o = f;
    if (!shadow_cfg.enable) return o;
    lm   = (f.l < 0) ? longint'(-longint'(f.l)) : longint'(f.l);
    rm   = (f.r < 0) ? longint'(-longint'(f.r)) : longint'(f.r);
    peak = (lm > rm) ? lm : rm;
    lvl_mag = 24576;
    if (peak != 0) begin
      p = 0;
      while ((peak >> (p + 1)) != 0) p++;
      frac = (peak << (31 - p)) & 64'h7FFF_FFFF;
      idx  = (frac * 256) >> 31;
      m    = longint'(SB - 1 - p) * 65536 - log_tab[idx];
      lvl_mag = (m * 394566 + (64'd1 << 23)) >> 24;
      if (lvl_mag > 24576) lvl_mag = 24576;
    end
    // attack while the level sits above the envelope
    c       = (-longint'(lvl_mag) > env_db) ? shadow_cfg.attack_coeff : shadow_cfg.release_coeff;
    env_mag = -env_db;
    env_mag = (c * env_mag + (65536 - c) * lvl_mag + 32768) >> 16;
    env_db  = -int'(env_mag);

    // soft-knee gain computer
    q   = 32768 - ((shadow_cfg.inverse_ratio > 32768) ? 32768 : shadow_cfg.inverse_ratio);
    thr = $signed(shadow_cfg.threshold_db);
    kn  = shadow_cfg.knee_db;
    d   = env_db - thr;
    d2  = 2 * d;
    if (d2 <= -kn) gmag = 0;
    else if (d2 >= kn) gmag = (longint'(d) * q + 16384) >> 15;
    else begin
      x    = d2 + kn;
      den  = kn << 18;
      gmag = (q * x * x + (den >> 1)) / den;
    end

    // dB back to linear, then makeup
    n   = (gmag * 10885 + 128) >> 8;
    lin = 64'd1 << 30;
    for (int k = 15; k >= 0; k--)
      if (n[k]) lin = (lin * root_tab[k]) >> 30;
    lin = ((n >> 16) >= 31) ? 0 : (lin >> (n >> 16));
    g   = (lin * shadow_cfg.makeup_gain + (64'd1 << 19)) >> 20;
    o.l = apply_gain(f.l, g);
    o.r = apply_gain(f.r, g);
    return o;
  endfunction

  // ---------------------------------------------------------------- bus side

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ENABLE:  shadow_cfg.enable        = v[0];
      REG_THRESH:  shadow_cfg.threshold_db  = v[14:0];
      REG_IRATIO:  shadow_cfg.inverse_ratio = v[15:0];
      REG_KNEE:    shadow_cfg.knee_db       = v[12:0];
      REG_ATTACK:  shadow_cfg.attack_coeff  = v[15:0];
      REG_RELEASE: shadow_cfg.release_coeff = v[15:0];
      REG_MAKEUP:  shadow_cfg.makeup_gain   = v[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic en, input logic [14:0] thr, input logic [15:0] ir,
                           input logic [12:0] kn, input logic [15:0] att,
                           input logic [15:0] rel, input logic [14:0] mk);
    reg_write(REG_ENABLE, 32'(en));
    reg_write(REG_THRESH, 32'(thr));
    reg_write(REG_IRATIO, 32'(ir));
    reg_write(REG_KNEE, 32'(kn));
    reg_write(REG_ATTACK, 32'(att));
    reg_write(REG_RELEASE, 32'(rel));
    reg_write(REG_MAKEUP, 32'(mk));
  endtask

  // let the pipe run dry before touching registers
  task automatic drain();
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- word flow

  task automatic send_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                           input logic be, input logic known,
                           input logic signed [SB-1:0] el, input logic signed [SB-1:0] er);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    left_in   <= l;
    right_in  <= r;
    block_end <= be;
    known_q   <= known;
    known_l   <= el;
    known_r   <= er;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  // accept side: predictor runs on every accepted word so the envelope stays in step
  always @(posedge clk) begin
    frame_t f, pred;
    if (!rst && in_valid && in_ready) begin
      f.l  = left_in;
      f.r  = right_in;
      f.be = block_end;
      pred = compress_frame(f);
      if (known_q) begin
        pred.l = known_l;
        pred.r = known_r;
      end
      expected_frames.push_back(pred);
    end
  end

  // receiver: random stall and in-order compare
  always @(posedge clk) begin
    frame_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected word L=%0d R=%0d be=%0b", $time,
                   left_out, right_out, block_end_out);
          errors++;
        end else begin
          e = expected_frames.pop_front();
          if (left_out !== e.l) begin
            $display("%0t: left_out expected %0d got %0d", $time, e.l, left_out);
            errors++;
          end
          if (right_out !== e.r) begin
            $display("%0t: right_out expected %0d got %0d", $time, e.r, right_out);
            errors++;
          end
          if (block_end_out !== e.be) begin
            $display("%0t: block_end_out expected %0b got %0b", $time, e.be, block_end_out);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("stereo_soft_knee_compressor_core_test: FAIL");
      $finish;
    end
  end

  // random sample: spread over every level from full scale down to silence
  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] s;
    s = SB'($urandom);
    case ($urandom_range(0, 15))
      0:       return FS_NEG;
      1:       return FS_POS;
      2:       return '0;
      default: return s >>> $urandom_range(0, 23);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  dir_row_t dir_rows [22];

  initial begin
    logic signed [SB-1:0] a, b;
    int cur_seg, burst;
    logic loud;
    errors = 0;
    cycles = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; left_in = '0; right_in = '0; block_end = 1'b0;
    known_q = 1'b0; known_l = '0; known_r = '0;
    shadow_cfg = '{enable: 1'b0, threshold_db: 15'd0, inverse_ratio: 16'd32768,
                   knee_db: 13'd0, attack_coeff: 16'd64000, release_coeff: 16'd65400,
                   makeup_gain: 15'd1024};
    env_db = -24576;
    build_tables();

    // seg 0: reset settings, pass-through; 1: defaults enabled (unity);
    // 2: deep limiter with wide knee; 3: muted; 4: inverse ratio above one (clamped to 1:1), odd threshold
    dir_rows = '{
      '{0, 24'sd0,   24'sd0,   1'b0, 1'b1, 24'sd0,   24'sd0},
      '{0, FS_POS,   FS_NEG,   1'b1, 1'b1, FS_POS,   FS_NEG},
      '{0, FS_NEG,   FS_POS,   1'b0, 1'b1, FS_NEG,   FS_POS},
      '{0, 24'sd1,   -24'sd1,  1'b1, 1'b1, 24'sd1,   -24'sd1},
      '{0, 24'sh555555, 24'shAAAAAA, 1'b0, 1'b1, 24'sh555555, 24'shAAAAAA},
      '{1, 24'sd0,   24'sd0,   1'b0, 1'b0, 24'sd0,   24'sd0},
      '{1, FS_NEG,   FS_NEG,   1'b1, 1'b0, 24'sd0,   24'sd0},
      '{1, FS_POS,   24'sd0,   1'b0, 1'b0, 24'sd0,   24'sd0},
      '{1, 24'sd1,   24'sd0,   1'b1, 1'b0, 24'sd0,   24'sd0},
      '{1, 24'sd4096, -24'sd4096, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{2, FS_NEG,   FS_POS,   1'b0, 1'b0, 24'sd0,   24'sd0},
      '{2, FS_POS,   FS_POS,   1'b1, 1'b0, 24'sd0,   24'sd0},
      '{2, 24'sd300000, -24'sd7, 1'b0, 1'b0, 24'sd0, 24'sd0},
      '{2, 24'sd0,   24'sd0,   1'b0, 1'b0, 24'sd0,   24'sd0},
      '{2, 24'sd2000, 24'sd1,  1'b1, 1'b0, 24'sd0,   24'sd0},
      '{3, FS_POS,   FS_NEG,   1'b1, 1'b1, 24'sd0,   24'sd0},
      '{3, 24'sd12345, -24'sd99, 1'b0, 1'b1, 24'sd0, 24'sd0},
      '{4, FS_NEG,   FS_NEG,   1'b0, 1'b0, 24'sd0,   24'sd0},
      '{4, 24'sd1,   24'sd2,   1'b1, 1'b0, 24'sd0,   24'sd0},
      '{4, 24'sd800000, 24'sd0, 1'b0, 1'b0, 24'sd0,  24'sd0},
      '{4, 24'sd0,   24'sd0,   1'b1, 1'b0, 24'sd0,   24'sd0},
      '{4, FS_POS,   24'sd5,   1'b0, 1'b0, 24'sd0,   24'sd0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk
    cur_seg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].seg != cur_seg) begin
        cur_seg = dir_rows[i].seg;
        in_valid <= 1'b0;
        drain();
        case (cur_seg)
          1: reg_write(REG_ENABLE, 1);
          2: write_all(1'b1, 15'h4400, 16'd0, 13'd5120, 16'd0, 16'd65535, 15'd1024);
          3: reg_write(REG_MAKEUP, 0);
          4: write_all(1'b1, 15'h4000, 16'd65535, 13'd8191, 16'd65535, 16'd0, 15'd32767);
          default: ;
        endcase
      end
      send_word(dir_rows[i].l, dir_rows[i].r, dir_rows[i].be, dir_rows[i].known,
                dir_rows[i].el, dir_rows[i].er);
    end

    // random phases: four idling patterns, two settings each
    for (int ph = 0; ph < 8; ph++) begin
      in_valid <= 1'b0;
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 7)   // top of every range
        write_all(1'b1, 15'h3FFF, 16'hFFFF, 13'h1FFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
      else if (ph == 6)
        write_all(1'b1, 15'h4400, 16'd1638, 13'd0, 16'd0, 16'd0, 15'd0);
      else
        write_all(($urandom_range(0, 5) != 0),
                  ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'(-$urandom_range(0, 15360)),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1638, 32768)),
                  ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5120)),
                  16'($urandom), 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1024, 32400)));
      // bursts of loud and quiet program so the envelope swings both ways
      burst = 0;
      loud  = 1'b0;
      for (int n = 0; n < 240; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          loud  = 1'($urandom_range(0, 1));
        end
        burst--;
        a = rand_sample();
        b = rand_sample();
        if (!loud) begin
          a = a >>> $urandom_range(8, 20);
          b = b >>> $urandom_range(8, 20);
        end
        send_word(a, b, 1'($urandom_range(0, 1)), 1'b0, '0, '0);
      end
    end

    in_valid <= 1'b0;
    drain();
    if (errors == 0)
      $display("stereo_soft_knee_compressor_core_test: PASS");
    else
      $display("stereo_soft_knee_compressor_core_test: FAIL");
    $finish;
  end

endmodule
